// ===== sv/wbps_pkg.sv =====
`timescale 1ns / 1ps
// Shared constants and codes for the wildcard byte pattern scanner.
// No dependencies; every other file imports this package.
package wbps_pkg;

    // Defaults for the top-level parameters
    localparam int PATTERN_MAX_DEF = 32;
    localparam int MATCH_LIMIT_DEF = 16;

    // Fixed field widths
    localparam int ADDR_W     = 48;
    localparam int BYTE_W     = 8;
    localparam int LEN_W      = 6;
    localparam int HOOK_W     = 8;
    localparam int STATUS_W   = 2;
    localparam int PAT_BYTES  = 32;
    localparam int PAT_BITS   = PAT_BYTES * BYTE_W;
    localparam int PAT_IDX_W  = $clog2(PAT_BYTES);
    localparam int WORD_W     = 64;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 64;

    // Result queue depth (power of two, at least 2)
    localparam int OUTQ_DEPTH = 4;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_PAT0 = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_PAT1 = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_PAT2 = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_PAT3 = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_MASK = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_LEN  = 3'd5;
    localparam logic [CFG_IDX_W-1:0] CFG_HOOK = 3'd6;

    // Result kinds
    localparam logic KIND_MATCH   = 1'b0;
    localparam logic KIND_SUMMARY = 1'b1;

    // Summary status codes
    localparam logic [STATUS_W-1:0] ST_NOT_FOUND = 2'd0;
    localparam logic [STATUS_W-1:0] ST_UNIQUE    = 2'd1;
    localparam logic [STATUS_W-1:0] ST_AMBIGUOUS = 2'd2;

endpackage

// ===== sv/wbps_if.sv =====
`timescale 1ns / 1ps
// Channel interfaces: scanned byte stream in, result beats out.
// Depends on wbps_pkg.
interface wbps_byte_if;
    import wbps_pkg::*;

    logic              valid;
    logic              ready;
    logic [BYTE_W-1:0] byte_value;
    logic [ADDR_W-1:0] byte_address;
    logic              span_first;
    logic              scan_last;

    modport source (output valid, byte_value, byte_address, span_first, scan_last,
                    input ready);
    modport sink   (input valid, byte_value, byte_address, span_first, scan_last,
                    output ready);
endinterface

interface wbps_res_if #(
    parameter int CNT_W = 5
);
    import wbps_pkg::*;

    logic                valid;
    logic                ready;
    logic                result_kind;
    logic [ADDR_W-1:0]   found_address;
    logic [STATUS_W-1:0] scan_status;
    logic [CNT_W-1:0]    match_total;
    logic                result_last;

    modport source (output valid, result_kind, found_address, scan_status, match_total,
                    result_last, input ready);
    modport sink   (input valid, result_kind, found_address, scan_status, match_total,
                    result_last, output ready);
endinterface

// ===== sv/wildcard_byte_pattern_scanner.sv =====
`timescale 1ns / 1ps
// Top level of the wildcard byte pattern scanner.
// Depends on wbps_pkg, wbps_if, wbps_match and wbps_out_queue.
//
//   Channel   Dir  Beat                                          Handshake
//   bytes     in   byte_value, byte_address, span_first, scan_last  valid/ready
//   results   out  result_kind, found_address, scan_status,
//                  match_total, result_last                      valid/ready
//   cfg_*     in   cfg_index, cfg_data                           cfg_we, no stall
//
// One byte per cycle while bytes.ready is high. The compare runs in the cycle a
// byte is accepted, and its results land in a four-entry result queue; the first
// shows on the results port the next cycle if the queue was empty. A byte that
// matches and ends the scan gives two beats (match record, then summary), drained
// one per cycle while results.ready is high. bytes.ready is low while the queue
// has fewer than two free slots: it drops when the result consumer holds off and
// after two two-beat bytes in a row. Reset clears config, counters and queue
// pointers; the window is not reset since bytes past the fill are never compared.
module wildcard_byte_pattern_scanner #(
    parameter int PATTERN_MAX = wbps_pkg::PATTERN_MAX_DEF,
    parameter int MATCH_LIMIT = wbps_pkg::MATCH_LIMIT_DEF,
    parameter int CNT_W       = $clog2(MATCH_LIMIT + 1)
) (
    input  logic                              clk,
    input  logic                              rst_n,
    wbps_byte_if.sink                         bytes,
    wbps_res_if.source                        results,
    input  logic                              cfg_we,
    input  logic [wbps_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [wbps_pkg::CFG_DATA_W-1:0]   cfg_data
);
    import wbps_pkg::*;

    localparam int WIN_W  = PATTERN_MAX * BYTE_W;
    localparam int FILL_W = $clog2(PATTERN_MAX + 1);
    localparam int RES_W  = 1 + ADDR_W + STATUS_W + CNT_W + 1;

    // ---------------- configuration registers ----------------
    logic [PAT_BITS-1:0]  pat_reg;
    logic [PAT_BYTES-1:0] mask_reg;
    logic [LEN_W-1:0]     len_reg;
    logic [HOOK_W-1:0]    hook_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pat_reg  <= '0;
            mask_reg <= '0;
            len_reg  <= '0;
            hook_reg <= '0;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                CFG_PAT0: pat_reg[0*WORD_W +: WORD_W] <= cfg_data[WORD_W-1:0];
                CFG_PAT1: pat_reg[1*WORD_W +: WORD_W] <= cfg_data[WORD_W-1:0];
                CFG_PAT2: pat_reg[2*WORD_W +: WORD_W] <= cfg_data[WORD_W-1:0];
                CFG_PAT3: pat_reg[3*WORD_W +: WORD_W] <= cfg_data[WORD_W-1:0];
                CFG_MASK: mask_reg <= cfg_data[PAT_BYTES-1:0];
                CFG_LEN:  len_reg  <= cfg_data[LEN_W-1:0];
                CFG_HOOK: hook_reg <= cfg_data[HOOK_W-1:0];
                default:  ; // unused indexes are dropped
            endcase
        end
    end

    // ---------------- scan state ----------------
    logic [WIN_W-1:0]  win_reg, win_next;      // newest byte in the low byte
    logic [FILL_W-1:0] fill_reg, fill_next;
    logic [CNT_W-1:0]  cnt_reg, cnt_next;
    logic [ADDR_W-1:0] first_reg, first_next;

    logic              accept;
    logic              room2;
    logic              hit;
    logic              hit_ok;
    logic              stopped;
    logic [ADDR_W-1:0] start_addr;
    logic [STATUS_W-1:0] sum_status;
    logic [ADDR_W-1:0] sum_addr;
    logic [RES_W-1:0]  rec_beat;
    logic [RES_W-1:0]  sum_beat;
    logic [RES_W-1:0]  head;
    logic              q_not_empty;

    assign accept = bytes.valid && bytes.ready;
    assign bytes.ready = room2;

    // shift the new byte in; the compare sees the window including it
    assign win_next = (win_reg << BYTE_W) | WIN_W'(bytes.byte_value);

    always_comb
    begin
        if (bytes.span_first)
        begin
            fill_next = FILL_W'(1);
        end
        else if (fill_reg < FILL_W'(PATTERN_MAX))
        begin
            fill_next = FILL_W'(fill_reg + FILL_W'(1));
        end
        else
        begin
            fill_next = fill_reg;
        end
    end

    wbps_match #(
        .PATTERN_MAX (PATTERN_MAX),
        .FILL_W      (FILL_W)
    ) u_match (
        .window    (win_next),
        .fill      (fill_next),
        .pattern   (pat_reg),
        .wild_mask (mask_reg),
        .length    (len_reg),
        .hit       (hit)
    );

    // once the limit is reached, further matches are not counted or reported
    assign stopped = (cnt_reg >= CNT_W'(MATCH_LIMIT));
    assign hit_ok  = hit && !stopped;

    // match starts length-1 bytes back, wrapping at 48 bits
    assign start_addr = ADDR_W'(bytes.byte_address - ADDR_W'(len_reg) + ADDR_W'(1));

    assign cnt_next   = hit_ok ? CNT_W'(cnt_reg + CNT_W'(1)) : cnt_reg;
    assign first_next = (hit_ok && (cnt_reg == '0)) ? start_addr : first_reg;

    // summary built from the counts including this byte's match
    always_comb
    begin
        if (cnt_next == '0)
        begin
            sum_status = ST_NOT_FOUND;
            sum_addr   = '0;
        end
        else if (cnt_next == CNT_W'(1))
        begin
            sum_status = ST_UNIQUE;
            sum_addr   = ADDR_W'(first_next + ADDR_W'(hook_reg));
        end
        else
        begin
            sum_status = ST_AMBIGUOUS;
            sum_addr   = '0;
        end
    end

    assign rec_beat = {KIND_MATCH, start_addr, ST_NOT_FOUND, cnt_next, !bytes.scan_last};
    assign sum_beat = {KIND_SUMMARY, sum_addr, sum_status, cnt_next, 1'b1};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fill_reg  <= '0;
            cnt_reg   <= '0;
            first_reg <= '0;
        end
        else if (accept)
        begin
            if (bytes.scan_last)
            begin
                // scan done: ready for the next one
                fill_reg  <= '0;
                cnt_reg   <= '0;
                first_reg <= '0;
            end
            else
            begin
                fill_reg  <= fill_next;
                cnt_reg   <= cnt_next;
                first_reg <= first_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            win_reg <= win_next;
        end
    end

    // ---------------- result queue ----------------
    wbps_out_queue #(
        .W     (RES_W),
        .DEPTH (OUTQ_DEPTH)
    ) u_outq (
        .clk       (clk),
        .rst_n     (rst_n),
        .push0     (accept && (hit_ok || bytes.scan_last)),
        .din0      (hit_ok ? rec_beat : sum_beat),
        .push1     (accept && hit_ok && bytes.scan_last),
        .din1      (sum_beat),
        .pop       (results.ready),
        .head      (head),
        .not_empty (q_not_empty),
        .room2     (room2)
    );

    assign results.valid = q_not_empty;
    assign {results.result_kind, results.found_address, results.scan_status,
            results.match_total, results.result_last} = head;

`ifndef SYNTH
    // match count never runs past the limit
    a_cnt_cap: assert property (@(posedge clk) disable iff (!rst_n)
        cnt_reg <= CNT_W'(MATCH_LIMIT))
        else $error("match count above limit");

    // scan end clears the per-scan state
    a_scan_clear: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && bytes.scan_last) |=> (cnt_reg == '0) && (fill_reg == '0)
                                        && (first_reg == '0))
        else $error("scan state not cleared after summary");

    // the summary beat is queued, so a result is offered next cycle
    a_sum_out: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && bytes.scan_last) |=> results.valid)
        else $error("no result offered after scan end");
`endif

endmodule

// ===== sv/wbps_match.sv =====
`timescale 1ns / 1ps
// Parallel wildcard compare of the byte window against the pattern.
// Depends on wbps_pkg.
module wbps_match #(
    parameter int PATTERN_MAX = wbps_pkg::PATTERN_MAX_DEF,
    parameter int FILL_W      = $clog2(PATTERN_MAX + 1)
) (
    input  logic [PATTERN_MAX*wbps_pkg::BYTE_W-1:0] window,
    input  logic [FILL_W-1:0]                       fill,
    input  logic [wbps_pkg::PAT_BITS-1:0]           pattern,
    input  logic [wbps_pkg::PAT_BYTES-1:0]          wild_mask,
    input  logic [wbps_pkg::LEN_W-1:0]              length,
    output logic                                    hit
);
    import wbps_pkg::*;

    localparam int CMP_W = 7;

    logic [CMP_W-1:0] len_x;
    logic [CMP_W-1:0] fill_x;

    assign len_x  = CMP_W'(length);
    assign fill_x = CMP_W'(fill);

    // Window position p (0 = newest) lines up with pattern byte length-1-p.
    always_comb
    begin
        logic [CMP_W-1:0]     idx;
        logic [PAT_IDX_W-1:0] sel;
        logic [BYTE_W-1:0]    pbyte;
        logic                 pwild;
        hit   = (len_x != '0) && (len_x <= CMP_W'(PATTERN_MAX)) && (fill_x >= len_x);
        idx   = '0;
        sel   = '0;
        pbyte = '0;
        pwild = 1'b0;
        for (int p = 0; p < PATTERN_MAX; p++)
        begin
            idx = len_x - CMP_W'(1) - CMP_W'(p);
            sel = idx[PAT_IDX_W-1:0];
            // positions past the stored pattern read as zero and never wild
            if (idx < CMP_W'(PAT_BYTES))
            begin
                pbyte = pattern[sel*BYTE_W +: BYTE_W];
                pwild = wild_mask[sel];
            end
            else
            begin
                pbyte = '0;
                pwild = 1'b0;
            end
            if ((CMP_W'(p) < len_x) && !pwild && (window[p*BYTE_W +: BYTE_W] != pbyte))
            begin
                hit = 1'b0;
            end
        end
    end

endmodule

// ===== sv/wbps_out_queue.sv =====
`timescale 1ns / 1ps
// Small result queue: up to two pushes and one pop per cycle.
// Depends on wbps_pkg for its default depth.
module wbps_out_queue #(
    parameter int W     = 8,
    parameter int DEPTH = wbps_pkg::OUTQ_DEPTH
) (
    input  logic         clk,
    input  logic         rst_n,
    input  logic         push0,
    input  logic [W-1:0] din0,
    input  logic         push1,
    input  logic [W-1:0] din1,
    input  logic         pop,
    output logic [W-1:0] head,
    output logic         not_empty,
    output logic         room2
);
    import wbps_pkg::*;

    localparam int PTR_W = $clog2(DEPTH);
    localparam int CNT_W = $clog2(DEPTH + 1);

    logic [W-1:0]     mem_reg [DEPTH];
    logic [PTR_W-1:0] wr_reg, wr_next;
    logic [PTR_W-1:0] rd_reg, rd_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic             do_pop;
    logic [CNT_W-1:0] n_push;

    assign not_empty = (cnt_reg != '0);
    assign room2     = (cnt_reg <= CNT_W'(DEPTH - 2));
    assign head      = mem_reg[rd_reg];
    assign do_pop    = pop && not_empty;
    assign n_push    = CNT_W'(push0) + CNT_W'(push0 && push1);

    assign wr_next  = PTR_W'(wr_reg + PTR_W'(n_push));
    assign rd_next  = do_pop ? PTR_W'(rd_reg + PTR_W'(1)) : rd_reg;
    assign cnt_next = CNT_W'(cnt_reg + n_push - CNT_W'(do_pop));

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_reg  <= '0;
            rd_reg  <= '0;
            cnt_reg <= '0;
        end
        else
        begin
            wr_reg  <= wr_next;
            rd_reg  <= rd_next;
            cnt_reg <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push0)
        begin
            mem_reg[wr_reg] <= din0;
        end
        if (push0 && push1)
        begin
            mem_reg[PTR_W'(wr_reg + PTR_W'(1))] <= din1;
        end
    end

endmodule

// ===== dv/wildcard_byte_pattern_scanner_tb.sv =====
`timescale 1ns / 1ps
// Self-checking bench for wildcard_byte_pattern_scanner: directed and random byte scans
// across many pattern settings, checked beat by beat against an in-bench predictor.
// Depends on wbps_pkg, wbps_if and the scanner RTL.
module wildcard_byte_pattern_scanner_tb;
    import wbps_pkg::*;

    localparam int CLK_HALF     = 5;
    localparam int RESET_CYCLES = 4;
    localparam int RANDOM_BYTES = 800;
    localparam int NUM_PHASES   = 12;
    localparam int SETTLE       = 4;        // settling wait after the result queue drains
    localparam int CYCLE_LIMIT  = 300000;
    localparam int HIT_CAP      = MATCH_LIMIT_DEF;
    localparam int WIN_BYTES    = PATTERN_MAX_DEF;
    localparam logic [CFG_IDX_W-1:0] CFG_UNUSED = 3'd7;  // past the last register

    // One result beat as the scanner presents it
    typedef struct packed {
        logic                kind;
        logic [ADDR_W-1:0]   addr;
        logic [STATUS_W-1:0] status;
        logic [4:0]          total;
        logic                last;
    } scan_result_t;

    // ------------------------------------------------------------------
    // Scoreboard: tracks pattern registers and the scan state, predicts
    // the beats each accepted byte causes, and checks them in order.
    // ------------------------------------------------------------------
    class scan_scoreboard;
        logic [63:0]       pat_word[4];
        logic [31:0]       wild;
        logic [LEN_W-1:0]  plen;
        logic [HOOK_W-1:0] hook;

        logic [7:0]        win[WIN_BYTES];
        int                fill;
        int                hits;
        logic [ADDR_W-1:0] first_hit;
        bit                stopped;

        scan_result_t      due_results[$];
        int                errors;
        int                n_match, n_none, n_unique, n_ambig, n_capped;

        function new();
            foreach (pat_word[i]) pat_word[i] = '0;
            foreach (win[i]) win[i] = '0;
            wild = '0;
            plen = '0;
            hook = '0;
            fill = 0;
            hits = 0;
            first_hit = '0;
            stopped = 0;
            errors = 0;
            n_match = 0;
            n_none = 0;
            n_unique = 0;
            n_ambig = 0;
            n_capped = 0;
        endfunction

        function void set_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
            case (idx)
                CFG_PAT0, CFG_PAT1, CFG_PAT2, CFG_PAT3: pat_word[idx] = data;
                CFG_MASK: wild = data[31:0];
                CFG_LEN:  plen = data[LEN_W-1:0];
                CFG_HOOK: hook = data[HOOK_W-1:0];
                default: ;
            endcase
        endfunction

        function logic [7:0] pat_byte(int i);
            return pat_word[i / 8][(i % 8) * 8 +: 8];
        endfunction

        // Pattern byte 0 lines up with the oldest window byte in play
        function bit window_hit();
            int pos;
            if (plen == 0 || plen > WIN_BYTES || fill < plen)
                return 0;
            for (int i = 0; i < plen; i++) begin
                pos = plen - 1 - i;
                if (!wild[i] && win[pos] != pat_byte(i))
                    return 0;
            end
            return 1;
        endfunction

        function void scan_byte(logic [7:0] value, logic [ADDR_W-1:0] addr, bit first,
                                bit last);
            scan_result_t r;
            logic [ADDR_W-1:0] start;
            for (int i = WIN_BYTES - 1; i > 0; i--)
                win[i] = win[i-1];
            win[0] = value;
            if (first)
                fill = 1;
            else if (fill < WIN_BYTES)
                fill++;

            if (!stopped && window_hit()) begin
                start = addr - ADDR_W'(plen - 1);
                hits++;
                if (hits == 1)
                    first_hit = start;
                if (hits >= HIT_CAP) begin
                    stopped = 1;
                    n_capped++;
                end
                r = '{KIND_MATCH, start, ST_NOT_FOUND, 5'(hits), !last};
                due_results = {due_results, r};
                n_match++;
            end

            if (last) begin
                r = '{KIND_SUMMARY, '0, ST_NOT_FOUND, 5'(hits), 1'b1};
                if (hits == 0) begin
                    n_none++;
                end
                else if (hits == 1) begin
                    r.status = ST_UNIQUE;
                    r.addr = first_hit + ADDR_W'(hook);
                    n_unique++;
                end
                else begin
                    r.status = ST_AMBIGUOUS;
                    n_ambig++;
                end
                due_results = {due_results, r};
                hits = 0;
                first_hit = '0;
                stopped = 0;
                fill = 0;
            end
        endfunction

        function void check_result(scan_result_t got);
            scan_result_t want;
            if (due_results.size() == 0) begin
                $error("result beat with nothing expected: kind %0d addr %h", got.kind,
                       got.addr);
                errors++;
                return;
            end
            want = due_results.pop_front();
            if (got.kind !== want.kind) begin
                $error("result_kind: expected %0d, got %0d", want.kind, got.kind);
                errors++;
            end
            if (got.addr !== want.addr) begin
                $error("found_address: expected %h, got %h", want.addr, got.addr);
                errors++;
            end
            if (got.status !== want.status) begin
                $error("scan_status: expected %0d, got %0d", want.status, got.status);
                errors++;
            end
            if (got.total !== want.total) begin
                $error("match_total: expected %0d, got %0d", want.total, got.total);
                errors++;
            end
            if (got.last !== want.last) begin
                $error("result_last: expected %0d, got %0d", want.last, got.last);
                errors++;
            end
        endfunction

        function int pending();
            return due_results.size();
        endfunction
    endclass

    // ------------------------------------------------------------------
    // Clock, reset, channels and the scanner
    // ------------------------------------------------------------------
    logic clk;
    logic rst_n;
    logic                  cfg_we;
    logic [CFG_IDX_W-1:0]  cfg_index;
    logic [CFG_DATA_W-1:0] cfg_data;

    wbps_byte_if            byte_ch();
    wbps_res_if #(.CNT_W(5)) res_ch();

    wildcard_byte_pattern_scanner u_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .bytes     (byte_ch),
        .results   (res_ch),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    scan_scoreboard sb = new();

    bit quiet;          // set for the final stretch: no idling on either side
    int bytes_sent;
    int cycles;

    initial clk = 1'b0;
    always #CLK_HALF clk = ~clk;

    // Watchdog: a hung handshake ends the run here
    always @(posedge clk)
    begin
        cycles++;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("simulation failed");
            $finish;
        end
    end

    // Result consumer: ready drops in short bursts, except in the quiet tail
    initial
    begin
        res_ch.ready <= 1'b0;
        @(posedge clk);
        while (!rst_n) @(posedge clk);
        forever
        begin
            if (!quiet && $urandom_range(0, 4) == 0)
            begin
                res_ch.ready <= 1'b0;
                repeat ($urandom_range(1, 6)) @(posedge clk);
            end
            res_ch.ready <= 1'b1;
            repeat ($urandom_range(1, 12)) @(posedge clk);
        end
    end

    // Result monitor: values sampled at the edge are the pre-edge ones
    always @(posedge clk)
    begin
        if (rst_n && res_ch.valid && res_ch.ready)
            sb.check_result('{res_ch.result_kind, res_ch.found_address, res_ch.scan_status,
                              res_ch.match_total, res_ch.result_last});
    end

    // ------------------------------------------------------------------
    // Drivers
    // ------------------------------------------------------------------

    // Present one byte beat, holding it until the scanner takes it.
    // valid stays high between back-to-back beats; a gap lowers it first.
    task automatic send_byte(input logic [7:0] value, input logic [ADDR_W-1:0] addr,
                             input bit first, input bit last);
        if (!quiet && $urandom_range(0, 4) == 0)
        begin
            byte_ch.valid <= 1'b0;
            repeat ($urandom_range(1, 6)) @(posedge clk);
        end
        byte_ch.valid        <= 1'b1;
        byte_ch.byte_value   <= value;
        byte_ch.byte_address <= addr;
        byte_ch.span_first   <= first;
        byte_ch.scan_last    <= last;
        @(posedge clk);
        while (!byte_ch.ready) @(posedge clk);
        sb.scan_byte(value, addr, first, last);
        bytes_sent++;
    endtask

    // Stop sending and let every predicted beat come out, plus the queue's
    // own latency, so a register write cannot overlap a byte in flight.
    task automatic wait_idle();
        byte_ch.valid <= 1'b0;
        while (sb.pending() != 0) @(posedge clk);
        repeat (SETTLE) @(posedge clk);
    endtask

    // One register write; the caller lowers cfg_we after its last write
    task automatic cfg_write(input logic [CFG_IDX_W-1:0] idx,
                             input logic [CFG_DATA_W-1:0] data);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        @(posedge clk);
        sb.set_reg(idx, data);
    endtask

    // Write all seven registers. Bits above the mask, length and hook widths carry
    // junk so that masking to width is exercised every time.
    task automatic load_config(input logic [255:0] pat, input logic [31:0] mask,
                               input logic [LEN_W-1:0] len, input logic [HOOK_W-1:0] hook);
        wait_idle();
        cfg_write(CFG_PAT0, pat[63:0]);
        cfg_write(CFG_PAT1, pat[127:64]);
        cfg_write(CFG_PAT2, pat[191:128]);
        cfg_write(CFG_PAT3, pat[255:192]);
        cfg_write(CFG_MASK, {$urandom, mask});
        cfg_write(CFG_LEN, {$urandom, 26'($urandom), len});
        cfg_write(CFG_HOOK, {$urandom, 24'($urandom), hook});
        cfg_we <= 1'b0;
    endtask

    // One span of consecutive addresses. Filler bytes lean toward pattern
    // bytes so short patterns also hit by chance; up to two full pattern
    // copies are planted unless this is a noise span. A few spans drop their
    // start flag or carry a stray one mid-span to break planted copies.
    task automatic send_span(input bit ends_scan);
        logic [7:0]        span_bytes[64];
        logic [ADDR_W-1:0] base;
        int                n;
        int                off;
        bit                planted;
        bit                first;
        planted = (sb.plen >= 1 && sb.plen <= WIN_BYTES);
        n = $urandom_range(1, 8) + (planted ? int'(sb.plen) : 0);
        if ($urandom_range(0, 4) == 0)
            n += $urandom_range(0, 20);
        for (int k = 0; k < n; k++)
            span_bytes[k] = $urandom_range(0, 1) ? sb.pat_byte($urandom_range(0, 31))
                                                 : 8'($urandom_range(0, 255));
        if (planted && $urandom_range(0, 9) != 0 && n >= sb.plen)
        begin
            repeat ($urandom_range(0, 2))
            begin
                off = $urandom_range(0, n - sb.plen);
                for (int i = 0; i < sb.plen; i++)
                    if (!sb.wild[i])
                        span_bytes[off + i] = sb.pat_byte(i);
            end
        end
        case ($urandom_range(0, 3))
            0:       base = '1 - ADDR_W'($urandom_range(0, 40));   // wraps through zero
            1:       base = ADDR_W'($urandom_range(0, 40));
            default: base = ADDR_W'({$urandom, $urandom});
        endcase
        for (int k = 0; k < n; k++)
        begin
            first = (k == 0) ? ($urandom_range(0, 9) != 0) : ($urandom_range(0, 39) == 0);
            send_byte(span_bytes[k], base + ADDR_W'(k), first, ends_scan && k == n - 1);
        end
    endtask

    // A scan of one to three spans; most end with the scan-end flag, the rest
    // run on into the next scan
    task automatic send_scan();
        int  spans;
        bit  closes;
        spans  = $urandom_range(1, 3);
        closes = ($urandom_range(0, 6) != 0);
        for (int s = 0; s < spans; s++)
            send_span(closes && s == spans - 1);
    endtask

    // Settings per phase: the first eight hit the extremes, the rest are
    // short random patterns with a sprinkling of wildcards
    task automatic phase_config(input int ph);
        logic [255:0]      pat;
        logic [31:0]       mask;
        logic [LEN_W-1:0]  len;
        logic [HOOK_W-1:0] hook;
        for (int w = 0; w < 8; w++)
            pat[w*32 +: 32] = $urandom;
        mask = $urandom & $urandom;
        len  = LEN_W'($urandom_range(1, 12));
        hook = HOOK_W'($urandom_range(0, 255));
        case (ph)
            0: begin len = 1;  mask = '1; hook = '1; end   // every byte hits: match cap
            1: begin len = 32; mask = '0; hook = '0; end   // longest, exact
            2: begin len = 32; mask = '1; end              // longest, all wildcards
            3: len = 33;                                   // longer than the window
            4: len = 63;
            5: begin pat = '0; mask = '0; len = 4; end
            6: begin pat = '1; mask = $urandom & $urandom & $urandom; len = 8; hook = '0; end
            7: len = 0;                                    // never matches
            default: ;
        endcase
        load_config(pat, mask, len, hook);
    endtask

    // Hand-picked scans: zero length after reset, one-byte pattern matching
    // on the scan-end byte, hook wrap past the top address, wildcard in the
    // middle, match start wrapping below zero, span restart that hides an old
    // window match, ambiguous and unique summaries, and a write to the
    // unused register index.
    task automatic directed_scans();
        send_byte(8'hFF, '1, 1, 1);

        load_config(256'hAB, 32'h0, 6'd1, 8'hFF);
        send_byte(8'hAB, '1, 1, 1);
        send_byte(8'h00, 48'h0, 1, 0);
        send_byte(8'hAB, 48'h1, 0, 0);
        send_byte(8'hAA, 48'h2, 0, 1);

        load_config(256'h33_22_11, 32'h2, 6'd3, 8'h10);
        send_byte(8'h11, '1, 1, 0);
        send_byte(8'hEE, 48'h0, 0, 0);
        send_byte(8'h33, 48'h1, 0, 0);
        send_byte(8'h11, 48'h2, 0, 0);
        send_byte(8'h22, 48'h3, 0, 0);
        send_byte(8'h33, 48'h4, 0, 0);
        send_byte(8'h11, 48'd100, 1, 0);
        send_byte(8'h22, 48'd101, 0, 0);
        send_byte(8'h33, 48'd200, 1, 0);
        send_byte(8'h00, 48'd201, 0, 1);

        send_byte(8'h11, 48'h10, 1, 0);
        send_byte(8'h22, 48'h11, 0, 0);
        send_byte(8'h33, 48'h12, 0, 1);

        wait_idle();
        cfg_write(CFG_UNUSED, '1);
        cfg_we <= 1'b0;
        send_byte(8'h11, 48'h8000_0000_0000, 1, 0);
        send_byte(8'h00, 48'h8000_0000_0001, 0, 0);
        send_byte(8'h33, 48'h8000_0000_0002, 0, 1);
    endtask

    // ------------------------------------------------------------------
    // Main sequence
    // ------------------------------------------------------------------
    initial
    begin
        int base_count;
        quiet      = 0;
        bytes_sent = 0;
        cycles     = 0;
        rst_n                <= 1'b0;
        cfg_we               <= 1'b0;
        cfg_index            <= '0;
        cfg_data             <= '0;
        byte_ch.valid        <= 1'b0;
        byte_ch.byte_value   <= '0;
        byte_ch.byte_address <= '0;
        byte_ch.span_first   <= 1'b0;
        byte_ch.scan_last    <= 1'b0;
        repeat (RESET_CYCLES) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        directed_scans();

        base_count = bytes_sent;
        for (int ph = 0; ph < NUM_PHASES; ph++)
        begin
            phase_config(ph);
            quiet = (ph == NUM_PHASES - 1);
            while (bytes_sent < base_count + (ph + 1) * RANDOM_BYTES / NUM_PHASES)
                send_scan();
        end

        wait_idle();
        repeat (SETTLE) @(posedge clk);

        $display("scanned %0d bytes over %0d settings: %0d match beats, match cap hit %0d times",
                 bytes_sent, NUM_PHASES + 3, sb.n_match, sb.n_capped);
        $display("summaries: %0d not found, %0d unique, %0d ambiguous",
                 sb.n_none, sb.n_unique, sb.n_ambig);
        if (sb.errors == 0 && sb.pending() == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

endmodule
